// ===== hdl/iwwl_pkg.sv =====
// Package for the interval walk weight lookup block: field widths, command and
// register codes, sequencer states and the control structs of the walk unit.
// No dependencies.
package iwwl_pkg;

  localparam int CMD_W         = 2;
  localparam int ELEM_FIELD_W  = 4;
  localparam int SLOT_W        = 10;
  localparam int TIME_FIELD_W  = 32;
  localparam int COUNT_FIELD_W = 5;
  localparam int WORD_W        = 64;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_INTERVAL,
    CMD_SET_COUNT,
    CMD_WRITE_WEIGHT,
    CMD_QUERY
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONSTANT_MODE,
    CFG_CONSTANT_WEIGHT,
    CFG_SNAP_WINDOW
  } cfg_idx_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_WALK,
    ST_RESOLVE,
    ST_WREAD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } walk_ctl_t;

  typedef struct packed {
    logic hit;
  } walk_stat_t;

endpackage

// ===== hdl/iwwl_in_if.sv =====
// Input channel of the interval walk weight lookup block.
// Depends on iwwl_pkg.
interface iwwl_in_if import iwwl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  cmd_t                     command;
  logic [ELEM_FIELD_W-1:0]  element;
  logic [SLOT_W-1:0]        slot;
  logic [TIME_FIELD_W-1:0]  iv_first;
  logic [TIME_FIELD_W-1:0]  iv_last;
  logic [COUNT_FIELD_W-1:0] interval_count;
  logic [WORD_W-1:0]        weight_word;
  logic [TIME_FIELD_W-1:0]  query_time;

  modport source (output valid, command, element, slot, iv_first, iv_last,
                  interval_count, weight_word, query_time, input ready);
  modport sink (input valid, command, element, slot, iv_first, iv_last,
                interval_count, weight_word, query_time, output ready);
endinterface

// ===== hdl/iwwl_out_if.sv =====
// Result channel of the interval walk weight lookup block.
// Depends on iwwl_pkg.
interface iwwl_out_if import iwwl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] weight_out;
  logic              status;

  modport source (output valid, weight_out, status, input ready);
  modport sink (input valid, weight_out, status, output ready);
endinterface

// ===== hdl/iwwl_cfg_if.sv =====
// Configuration write channel of the interval walk weight lookup block.
// Depends on iwwl_pkg.
interface iwwl_cfg_if import iwwl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/iwwl_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module iwwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/iwwl_walk.sv =====
// Interval walk unit: takes one stored interval per step and tracks the
// running weight position, the first containment and the first snap.
// Depends on iwwl_pkg.
module iwwl_walk import iwwl_pkg::*; #(
  parameter int MAX_WEIGHTS = 1024,
  parameter int TIME_W = 32,
  localparam int POS_W = $clog2(MAX_WEIGHTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  walk_ctl_t         ctl,
  input  logic [TIME_W-1:0] start_t,
  input  logic [TIME_W-1:0] end_t,
  input  logic [TIME_W-1:0] query_t,
  input  logic [TIME_W-1:0] snap_win,
  output walk_stat_t        stat,
  output logic [POS_W-1:0]  pos
);

  localparam int SUM_W = ((TIME_W > POS_W) ? TIME_W : POS_W) + 2;

  // Position plus span plus extra, saturated at the table size.
  function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] p,
                                               input logic [TIME_W-1:0] span,
                                               input logic extra);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(p) + SUM_W'(span) + SUM_W'(extra);
    if (SUM_W'(span) >= SUM_W'(MAX_WEIGHTS) || sum > SUM_W'(MAX_WEIGHTS)) begin
      advance = POS_W'(MAX_WEIGHTS);
    end else begin
      advance = sum[POS_W-1:0];
    end
  endfunction

  logic              cont_r, snap_r, pend_r;
  logic [POS_W-1:0]  idx_r, cont_pos_r, snap_pos_r, pend_a0_r, pend_a1_r;
  logic [TIME_W-1:0] pend_d_r;

  logic              iv_ok, contain, snap_before, snap_after, nearer;
  logic [TIME_W-1:0] span, offset, d_before, d_after;
  logic [POS_W-1:0]  a_off, a0, a1;

  always_comb begin
    iv_ok       = end_t >= start_t;
    contain     = query_t >= start_t && query_t <= end_t;
    span        = end_t - start_t;
    offset      = query_t - start_t;
    d_before    = start_t - query_t;
    d_after     = query_t - end_t;
    snap_before = query_t < start_t && d_before <= snap_win;
    snap_after  = query_t > end_t && d_after <= snap_win;
    nearer      = query_t < start_t && d_before < pend_d_r;
    a_off       = advance(idx_r, offset, 1'b0);
    a0          = advance(idx_r, span, 1'b0);
    a1          = advance(idx_r, span, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cont_r <= 1'b0;
      snap_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (ctl.clear) begin
      cont_r <= 1'b0;
      snap_r <= 1'b0;
      pend_r <= 1'b0;
    end else if (ctl.step && iv_ok) begin
      if (!cont_r && contain) begin
        cont_r <= 1'b1;
      end
      if (pend_r) begin
        pend_r <= 1'b0;
        snap_r <= 1'b1;
      end else if (!snap_r && snap_before) begin
        snap_r <= 1'b1;
      end else if (!snap_r && snap_after) begin
        pend_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      idx_r <= '0;
    end else if (ctl.step && iv_ok) begin
      idx_r <= a1;
      if (!cont_r && contain) begin
        cont_pos_r <= a_off;
      end
      if (pend_r) begin
        snap_pos_r <= nearer ? pend_a1_r : pend_a0_r;
      end else if (!snap_r && snap_before) begin
        snap_pos_r <= idx_r;
      end else if (!snap_r && snap_after) begin
        pend_d_r  <= d_after;
        pend_a0_r <= a0;
        pend_a1_r <= a1;
      end
    end
  end

  // A snap after the last valid interval that is still unresolved keeps its end.
  assign stat.hit = cont_r | snap_r | pend_r;
  assign pos = cont_r ? cont_pos_r : (snap_r ? snap_pos_r : pend_a0_r);

endmodule

// ===== hdl/interval_walk_weight_lookup_core.sv =====
// Top level of the interval walk weight lookup block: sequencer, configuration
// registers, interval, count and weight memories, and the result register.
// Depends on iwwl_pkg, the three channel interfaces, iwwl_ram and iwwl_walk.
//
// The input channel carries commands: write interval, set interval count,
// write weight and query. Every accepted item gives exactly one transfer on
// the result channel; writes answer zero with status OK. The configuration
// channel is always ready and sets constant mode, the constant weight and the
// snapping window; it must be written only while the block is idle, a rule for
// the user that the block itself does not enforce. One item is worked on at a
// time. A write, a constant-mode query and a query on a bad element go straight
// from acceptance to the loaded result register. A walking query reads the
// interval count, then one stored interval per cycle, resolves the position
// and, when it finds its weight, reads the weight memory before the result is
// loaded. The block then returns to idle and can accept the next item while
// that result may still wait in the output register.
// After reset the interval count memory is cleared entry by entry, during
// which no item is accepted. When the receiver stalls, a finished result stays
// in the output register and the next one waits until it is taken.
module interval_walk_weight_lookup_core import iwwl_pkg::*; #(
  parameter int ELEMENTS = 16,
  parameter int MAX_INTERVALS = 16,
  parameter int MAX_WEIGHTS = 1024,
  parameter int TIME_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  iwwl_in_if.sink    in_chan,
  iwwl_out_if.source out_chan,
  iwwl_cfg_if.sink   cfg_chan
);

  localparam int TW       = (TIME_BITS < TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;
  localparam int EW       = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int ELEM_CW  = ((EW > ELEM_FIELD_W) ? EW : ELEM_FIELD_W) + 1;
  localparam int CNT_W    = $clog2(MAX_INTERVALS + 1);
  localparam int CNT_CW   = ((CNT_W > COUNT_FIELD_W) ? CNT_W : COUNT_FIELD_W) + 1;
  localparam int POS_W    = $clog2(MAX_WEIGHTS + 1);
  localparam int SLOT_CW  = ((POS_W > SLOT_W) ? POS_W : SLOT_W) + 1;
  localparam int IA_DEPTH = ELEMENTS * MAX_INTERVALS;
  localparam int IA_W     = (IA_DEPTH > 1) ? $clog2(IA_DEPTH) : 1;
  localparam int WA_DEPTH = ELEMENTS * MAX_WEIGHTS;
  localparam int WA_W     = (WA_DEPTH > 1) ? $clog2(WA_DEPTH) : 1;

  state_t state_r, state_nxt;

  logic              constant_mode_r;
  logic [WORD_W-1:0] constant_weight_r;
  logic [TW-1:0]     snap_win_r;

  logic [EW-1:0]     clr_r;
  logic [CNT_W-1:0]  n_r, i_r;
  logic [IA_W-1:0]   base_i_r;
  logic [WA_W-1:0]   base_w_r;
  logic [TW-1:0]     t_r;
  logic [WORD_W-1:0] res_w_r, out_w_r;
  logic              res_st_r, out_st_r, out_valid_r;

  logic              acc, out_free, elem_ok, slot_int_ok, slot_w_ok;
  logic [EW-1:0]     elem_idx;
  logic [CNT_W-1:0]  cnt_sat, i_inc;
  logic [IA_W-1:0]   elem_base_i;
  logic [WA_W-1:0]   elem_base_w;

  logic              int_we, int_re, cnt_we, cnt_re, w_we, w_re, pos_ok;
  logic [IA_W-1:0]   int_waddr, int_raddr;
  logic [2*TW-1:0]   int_rdata;
  logic [EW-1:0]     cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic [WA_W-1:0]   w_waddr, w_raddr;
  logic [WORD_W-1:0] w_rdata;

  walk_ctl_t         walk_ctl;
  walk_stat_t        walk_stat;
  logic [POS_W-1:0]  walk_pos;

  always_comb begin
    acc         = in_chan.valid && in_chan.ready;
    out_free    = !out_valid_r || out_chan.ready;
    elem_idx    = EW'(in_chan.element);
    elem_ok     = ELEM_CW'(in_chan.element) < ELEM_CW'(ELEMENTS);
    slot_int_ok = SLOT_CW'(in_chan.slot) < SLOT_CW'(MAX_INTERVALS);
    slot_w_ok   = SLOT_CW'(in_chan.slot) < SLOT_CW'(MAX_WEIGHTS);
    if (CNT_CW'(in_chan.interval_count) > CNT_CW'(MAX_INTERVALS)) begin
      cnt_sat = CNT_W'(MAX_INTERVALS);
    end else begin
      cnt_sat = CNT_W'(in_chan.interval_count);
    end
    elem_base_i = IA_W'(elem_idx) * IA_W'(MAX_INTERVALS);
    elem_base_w = WA_W'(elem_idx) * WA_W'(MAX_WEIGHTS);
    i_inc       = i_r + CNT_W'(1);
    pos_ok      = walk_pos < POS_W'(MAX_WEIGHTS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      constant_mode_r   <= 1'b0;
      constant_weight_r <= '0;
      snap_win_r        <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        CFG_CONSTANT_MODE:   constant_mode_r   <= cfg_chan.data[0];
        CFG_CONSTANT_WEIGHT: constant_weight_r <= cfg_chan.data;
        CFG_SNAP_WINDOW:     snap_win_r        <= cfg_chan.data[TW-1:0];
        default:             ;
      endcase
    end
  end

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == EW'(ELEMENTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          if (in_chan.command == CMD_QUERY && !constant_mode_r && elem_ok) begin
            state_nxt = ST_COUNT;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_COUNT:   state_nxt = (cnt_rdata == '0) ? ST_RESOLVE : ST_WALK;
      ST_WALK: begin
        if (i_inc >= n_r) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: state_nxt = (walk_stat.hit && pos_ok) ? ST_WREAD : ST_DONE;
      ST_WREAD:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready  = state_r == ST_IDLE;
    int_we         = acc && in_chan.command == CMD_WRITE_INTERVAL && elem_ok && slot_int_ok;
    int_waddr      = elem_base_i + IA_W'(in_chan.slot);
    int_re         = (state_r == ST_COUNT && cnt_rdata != '0) ||
                     (state_r == ST_WALK && i_inc < n_r);
    int_raddr      = base_i_r + ((state_r == ST_COUNT) ? '0 : IA_W'(i_inc));
    cnt_we         = (state_r == ST_CLEAR) ||
                     (acc && in_chan.command == CMD_SET_COUNT && elem_ok);
    cnt_waddr      = (state_r == ST_CLEAR) ? clr_r : elem_idx;
    cnt_wdata      = (state_r == ST_CLEAR) ? '0 : cnt_sat;
    cnt_re         = acc && in_chan.command == CMD_QUERY;
    w_we           = acc && in_chan.command == CMD_WRITE_WEIGHT && elem_ok && slot_w_ok;
    w_waddr        = elem_base_w + WA_W'(in_chan.slot);
    w_re           = state_r == ST_RESOLVE && walk_stat.hit && pos_ok;
    w_raddr        = base_w_r + WA_W'(walk_pos);
    walk_ctl.clear = acc;
    walk_ctl.step  = state_r == ST_WALK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + EW'(1);
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      base_i_r <= elem_base_i;
      base_w_r <= elem_base_w;
      t_r      <= in_chan.query_time[TW-1:0];
      if (in_chan.command == CMD_QUERY && constant_mode_r) begin
        res_w_r <= constant_weight_r;
      end else begin
        res_w_r <= '0;
      end
      if (in_chan.command == CMD_QUERY && !constant_mode_r && !elem_ok) begin
        res_st_r <= STATUS_MISS;
      end else begin
        res_st_r <= STATUS_OK;
      end
    end
    if (state_r == ST_COUNT) begin
      n_r <= cnt_rdata;
      i_r <= '0;
    end else if (state_r == ST_WALK) begin
      i_r <= i_inc;
    end
    if (state_r == ST_RESOLVE && !w_re) begin
      res_w_r  <= '0;
      res_st_r <= STATUS_MISS;
    end
    if (state_r == ST_WREAD) begin
      res_w_r  <= w_rdata;
      res_st_r <= STATUS_OK;
    end
    if (state_r == ST_DONE && out_free) begin
      out_w_r  <= res_w_r;
      out_st_r <= res_st_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.weight_out = out_w_r;
  assign out_chan.status     = out_st_r;

  iwwl_ram #(.WIDTH(2 * TW), .DEPTH(IA_DEPTH)) u_interval_ram (
    .clk   (clk),
    .we    (int_we),
    .waddr (int_waddr),
    .wdata ({in_chan.iv_last[TW-1:0], in_chan.iv_first[TW-1:0]}),
    .re    (int_re),
    .raddr (int_raddr),
    .rdata (int_rdata)
  );

  iwwl_ram #(.WIDTH(CNT_W), .DEPTH(ELEMENTS)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (elem_idx),
    .rdata (cnt_rdata)
  );

  iwwl_ram #(.WIDTH(WORD_W), .DEPTH(WA_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (in_chan.weight_word),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  iwwl_walk #(.MAX_WEIGHTS(MAX_WEIGHTS), .TIME_W(TW)) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (walk_ctl),
    .start_t  (int_rdata[TW-1:0]),
    .end_t    (int_rdata[2*TW-1:TW]),
    .query_t  (t_r),
    .snap_win (snap_win_r),
    .stat     (walk_stat),
    .pos      (walk_pos)
  );

endmodule

// ===== hdl/iwwl_checker.sv =====
// Port-level checks for the interval walk weight lookup block and the bind
// that attaches them to the top level. Depends on the top level's ports.
module iwwl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_weight,
  input logic        out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transfer dropped while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_weight == 64'd0)
    else $error("error status with a nonzero weight");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

endmodule

bind interval_walk_weight_lookup_core iwwl_checker u_iwwl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_weight (out_chan.weight_out),
  .out_status (out_chan.status)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for interval_walk_weight_lookup_core: directed and random
// command traffic, with an in-bench model of interval storage, walking and snapping.
// Depends on iwwl_pkg, the three channel interfaces and the core itself.
module tb_top;
  import iwwl_pkg::*;

  localparam int ELEMENTS      = 16;
  localparam int MAX_INTERVALS = 16;
  localparam int MAX_WEIGHTS   = 1024;
  localparam int TIME_BITS     = 32;
  localparam longint RUN_LIMIT = 64'd8_000_000;

  typedef struct packed {
    cmd_t                     command;
    logic [ELEM_FIELD_W-1:0]  element;
    logic [SLOT_W-1:0]        slot;
    logic [TIME_FIELD_W-1:0]  iv_first;
    logic [TIME_FIELD_W-1:0]  iv_last;
    logic [COUNT_FIELD_W-1:0] interval_count;
    logic [WORD_W-1:0]        weight_word;
    logic [TIME_FIELD_W-1:0]  query_time;
  } lookup_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] weight;
    logic              status;
  } lookup_answer_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  iwwl_in_if  in_chan ();
  iwwl_out_if out_chan ();
  iwwl_cfg_if cfg_chan ();

  interval_walk_weight_lookup_core #(
    .ELEMENTS(ELEMENTS),
    .MAX_INTERVALS(MAX_INTERVALS),
    .MAX_WEIGHTS(MAX_WEIGHTS),
    .TIME_BITS(TIME_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  // Model state of the lookup block.
  logic [TIME_FIELD_W-1:0]  iv_start [ELEMENTS][MAX_INTERVALS];
  logic [TIME_FIELD_W-1:0]  iv_end [ELEMENTS][MAX_INTERVALS];
  bit                       iv_known [ELEMENTS][MAX_INTERVALS];
  logic [COUNT_FIELD_W-1:0] iv_count [ELEMENTS];
  logic [WORD_W-1:0]        weight_mem [ELEMENTS][MAX_WEIGHTS];
  bit                       weight_known [ELEMENTS][MAX_WEIGHTS];
  bit                       mode_const;
  logic [WORD_W-1:0]        const_word;
  logic [TIME_FIELD_W-1:0]  snap_window;

  lookup_answer_t awaited_answers[$];

  int send_gap_pct;
  int out_stall_pct;
  int mismatch_count;
  int items_sent;
  int queries_sent;
  int misses_expected;
  int const_answers;
  int reg_writes;

  function automatic logic [WORD_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TIME_FIELD_W-1:0] clamp_time(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic longint unsigned advance_pos(longint unsigned pos, longint unsigned span,
                                                  longint unsigned extra);
    longint unsigned sum;
    if (span >= MAX_WEIGHTS) return MAX_WEIGHTS;
    sum = pos + span + extra;
    return (sum > MAX_WEIGHTS) ? MAX_WEIGHTS : sum;
  endfunction

  // Containment is checked over all intervals before any snapping is tried.
  function automatic bit locate_position(int elem, longint unsigned t,
                                         output longint unsigned pos);
    longint unsigned acc, s, e, ns;
    int n, j;
    pos = 0;
    n = iv_count[elem];
    acc = 0;
    for (int i = 0; i < n; i++) begin
      s = iv_start[elem][i];
      e = iv_end[elem][i];
      if (e >= s) begin
        if (t >= s && t <= e) begin
          pos = advance_pos(acc, t - s, 0);
          return 1'b1;
        end
        acc = advance_pos(acc, e - s, 1);
      end
    end
    acc = 0;
    for (int i = 0; i < n; i++) begin
      s = iv_start[elem][i];
      e = iv_end[elem][i];
      if (e >= s) begin
        if (t < s && s - t <= snap_window) begin
          pos = acc;
          return 1'b1;
        end
        if (t > e && t - e <= snap_window) begin
          j = i + 1;
          while (j < n && iv_end[elem][j] < iv_start[elem][j]) j++;
          if (j < n) begin
            ns = iv_start[elem][j];
            if (ns > t && ns - t < t - e) begin
              pos = advance_pos(acc, e - s, 1);
              return 1'b1;
            end
          end
          pos = advance_pos(acc, e - s, 0);
          return 1'b1;
        end
        acc = advance_pos(acc, e - s, 1);
      end
    end
    return 1'b0;
  endfunction

  function automatic lookup_answer_t apply_command(lookup_item_t it);
    lookup_answer_t ans;
    longint unsigned pos;
    ans.weight = '0;
    ans.status = STATUS_OK;
    case (it.command)
      CMD_WRITE_INTERVAL: begin
        if (it.slot < MAX_INTERVALS) begin
          iv_start[it.element][it.slot] = it.iv_first;
          iv_end[it.element][it.slot] = it.iv_last;
          iv_known[it.element][it.slot] = 1'b1;
        end
      end
      CMD_SET_COUNT: begin
        iv_count[it.element] = (it.interval_count > MAX_INTERVALS) ?
                               COUNT_FIELD_W'(MAX_INTERVALS) : it.interval_count;
      end
      CMD_WRITE_WEIGHT: begin
        weight_mem[it.element][it.slot] = it.weight_word;
        weight_known[it.element][it.slot] = 1'b1;
      end
      default: begin
        queries_sent++;
        if (mode_const) begin
          ans.weight = const_word;
          const_answers++;
        end else if (locate_position(it.element, it.query_time, pos) && pos < MAX_WEIGHTS) begin
          ans.weight = weight_mem[it.element][pos];
        end else begin
          ans.status = STATUS_MISS;
          misses_expected++;
        end
      end
    endcase
    return ans;
  endfunction

  function automatic lookup_item_t blank_item(cmd_t cmd, int elem);
    lookup_item_t it;
    it.command = cmd;
    it.element = ELEM_FIELD_W'(elem);
    it.slot = SLOT_W'($urandom);
    it.iv_first = $urandom;
    it.iv_last = $urandom;
    it.interval_count = COUNT_FIELD_W'($urandom);
    it.weight_word = random_word();
    it.query_time = $urandom;
    return it;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Valid stays high from one transfer to the next unless a gap is drawn.
  task automatic send_item(input lookup_item_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.command <= it.command;
    in_chan.element <= it.element;
    in_chan.slot <= it.slot;
    in_chan.iv_first <= it.iv_first;
    in_chan.iv_last <= it.iv_last;
    in_chan.interval_count <= it.interval_count;
    in_chan.weight_word <= it.weight_word;
    in_chan.query_time <= it.query_time;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    awaited_answers.push_back(apply_command(it));
    if (!(it.command == CMD_WRITE_INTERVAL && it.slot >= MAX_INTERVALS)) items_sent++;
  endtask

  task automatic write_interval(int elem, int slot, logic [31:0] st, logic [31:0] en);
    lookup_item_t it;
    it = blank_item(CMD_WRITE_INTERVAL, elem);
    it.slot = SLOT_W'(slot);
    it.iv_first = st;
    it.iv_last = en;
    send_item(it);
  endtask

  task automatic write_weight(int elem, int slot, logic [WORD_W-1:0] word);
    lookup_item_t it;
    it = blank_item(CMD_WRITE_WEIGHT, elem);
    it.slot = SLOT_W'(slot);
    it.weight_word = word;
    send_item(it);
  endtask

  // Every interval slot that becomes visible and is still unknown is written first.
  task automatic set_count(int elem, int cnt);
    lookup_item_t it;
    for (int s = 0; s < cnt && s < MAX_INTERVALS; s++) begin
      if (!iv_known[elem][s]) write_interval(elem, s, $urandom, $urandom);
    end
    it = blank_item(CMD_SET_COUNT, elem);
    it.interval_count = COUNT_FIELD_W'(cnt);
    send_item(it);
  endtask

  // The weight at the position a query will hit is written first if still unknown.
  task automatic run_query(int elem, logic [31:0] t);
    lookup_item_t it;
    longint unsigned pos;
    if (!mode_const && locate_position(elem, t, pos) && pos < MAX_WEIGHTS &&
        !weight_known[elem][pos]) begin
      write_weight(elem, int'(pos), random_word());
    end
    it = blank_item(CMD_QUERY, elem);
    it.query_time = t;
    send_item(it);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [WORD_W-1:0] data);
    settle();
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    case (idx)
      CFG_CONSTANT_MODE:   mode_const = data[0];
      CFG_CONSTANT_WEIGHT: const_word = data;
      CFG_SNAP_WINDOW:     snap_window = data[31:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic pick_window();
    logic [WORD_W-1:0] upper;
    upper = {$urandom, 32'h0};
    case ($urandom_range(0, 3))
      0:       write_reg(CFG_SNAP_WINDOW, upper);
      1:       write_reg(CFG_SNAP_WINDOW, upper | $urandom_range(1, 20));
      2:       write_reg(CFG_SNAP_WINDOW, upper | 32'hFFFF_FFFF);
      default: write_reg(CFG_SNAP_WINDOW, upper | $urandom);
    endcase
  endtask

  // Lays out sorted intervals with random gaps, lengths and a few reversed ones.
  task automatic build_element(int elem);
    longint unsigned cursor;
    int n, len, cnt;
    logic [31:0] st, en;
    n = ($urandom_range(0, 3) == 0) ? MAX_INTERVALS : $urandom_range(1, MAX_INTERVALS);
    cursor = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
    for (int s = 0; s < n; s++) begin
      cursor += $urandom_range(1, 40);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(900, 3000) : $urandom_range(0, 30);
      st = clamp_time(cursor);
      en = clamp_time(cursor + len);
      if (len > 0 && $urandom_range(0, 9) == 0) write_interval(elem, s, en, st);
      else write_interval(elem, s, st, en);
      cursor += len;
    end
    if (n == MAX_INTERVALS && $urandom_range(0, 1)) cnt = $urandom_range(MAX_INTERVALS, 31);
    else if ($urandom_range(0, 7) == 0) cnt = $urandom_range(0, n);
    else cnt = n;
    set_count(elem, cnt);
  endtask

  // Picks a time near an interval edge, often right at the snapping boundary.
  function automatic logic [31:0] near_edge(int elem);
    int pick, shift, reach;
    longint signed spot;
    pick = $urandom_range(0, MAX_INTERVALS - 1);
    if (iv_count[elem] != 0) pick = $urandom_range(0, iv_count[elem] - 1);
    if (!iv_known[elem][pick]) return $urandom;
    spot = $urandom_range(0, 1) ? iv_end[elem][pick] : iv_start[elem][pick];
    reach = (snap_window > 40) ? 43 : int'(snap_window) + 3;
    if ($urandom_range(0, 2) == 0 && snap_window < 1000)
      shift = int'(snap_window) + int'($urandom_range(0, 2)) - 1;
    else
      shift = $urandom_range(0, reach);
    if ($urandom_range(0, 1)) spot += shift;
    else spot -= shift;
    if (spot < 0) return '0;
    if (spot > 64'sd4294967295) return 32'hFFFF_FFFF;
    return spot[31:0];
  endfunction

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin : check_answers
    lookup_answer_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch($sformatf("result with none expected: weight %h status %0d",
                                  out_chan.weight_out, out_chan.status));
      end else begin
        want = awaited_answers.pop_front();
        if (out_chan.weight_out !== want.weight)
          report_mismatch($sformatf("weight_out %h, expected %h",
                                    out_chan.weight_out, want.weight));
        if (out_chan.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_chan.status, want.status));
      end
    end
  end

  task automatic test_reset_state();
    run_query(0, 32'h0);
    run_query(ELEMENTS - 1, 32'hFFFF_FFFF);
  endtask

  // Element 1: [100,109] [201,205] reversed [300,299] [400,400].
  task automatic test_walk_positions();
    write_interval(1, 0, 100, 109);
    write_interval(1, 1, 201, 205);
    write_interval(1, 2, 300, 299);
    write_interval(1, 3, 400, 400);
    write_interval(1, 1023, 0, 32'hFFFF_FFFF);
    set_count(1, 4);
    write_weight(1, MAX_WEIGHTS - 1, '1);
    run_query(1, 100);
    run_query(1, 109);
    run_query(1, 203);
    run_query(1, 400);
    run_query(1, 300);
    run_query(1, 150);
  endtask

  task automatic test_snapping();
    write_reg(CFG_SNAP_WINDOW, 100);
    run_query(1, 155);
    run_query(1, 156);
    run_query(1, 201);
    run_query(1, 420);
    run_query(1, 0);
    run_query(1, 300);
  endtask

  task automatic test_time_extremes();
    write_reg(CFG_SNAP_WINDOW, 32'hFFFF_FFFF);
    write_interval(2, 0, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    set_count(2, 1);
    run_query(2, 32'hFFFF_FFFF);
    run_query(2, 5);
    write_interval(3, 0, 0, 32'hFFFF_FFFF);
    set_count(3, 1);
    run_query(3, MAX_WEIGHTS - 1);
    run_query(3, MAX_WEIGHTS);
    write_reg(CFG_SNAP_WINDOW, 0);
  endtask

  task automatic test_constant_mode();
    write_reg(CFG_CONSTANT_WEIGHT, '1);
    write_reg(CFG_CONSTANT_MODE, 1);
    run_query(0, $urandom);
    write_reg(CFG_CONSTANT_WEIGHT, '0);
    run_query(1, 105);
    write_reg(CFG_CONSTANT_MODE, 0);
  endtask

  task automatic test_random_traffic(int target, int gap_pct, int stall_pct);
    int goal, pick, elem;
    send_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    write_reg(CFG_CONSTANT_MODE, random_word() & ~64'd1);
    pick_window();
    repeat (4) build_element($urandom_range(0, ELEMENTS - 1));
    goal = items_sent + target;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      elem = $urandom_range(0, ELEMENTS - 1);
      if (pick < 10) begin
        build_element(elem);
      end else if (pick < 70) begin
        run_query(elem, near_edge(elem));
      end else if (pick < 78) begin
        run_query(elem, $urandom);
      end else if (pick < 84) begin
        write_weight(elem, $urandom_range(0, MAX_WEIGHTS - 1), random_word());
      end else if (pick < 88) begin
        set_count(elem, $urandom_range(0, 31));
      end else if (pick < 93) begin
        if ($urandom_range(0, 1)) write_interval(elem, $urandom_range(0, 15), $urandom, $urandom);
        else write_interval(elem, $urandom_range(MAX_INTERVALS, 1023), $urandom, $urandom);
      end else if (pick < 98) begin
        run_query($urandom_range(0, ELEMENTS - 1), $urandom);
      end else begin
        case ($urandom_range(0, 2))
          0: write_reg(CFG_CONSTANT_MODE,
                       (random_word() & ~64'd1) | 64'($urandom_range(0, 3) == 0));
          1: write_reg(CFG_CONSTANT_WEIGHT, random_word());
          default: pick_window();
        endcase
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.command = CMD_WRITE_INTERVAL;
    in_chan.element = '0;
    in_chan.slot = '0;
    in_chan.iv_first = '0;
    in_chan.iv_last = '0;
    in_chan.interval_count = '0;
    in_chan.weight_word = '0;
    in_chan.query_time = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_CONSTANT_MODE;
    cfg_chan.data = '0;
    foreach (iv_count[e]) iv_count[e] = '0;
    mode_const = 1'b0;
    const_word = '0;
    snap_window = '0;
    send_gap_pct = 0;
    out_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_walk_positions();
    test_snapping();
    test_time_extremes();
    test_constant_mode();
    test_random_traffic(250, 0, 0);
    test_random_traffic(250, 83, 0);
    test_random_traffic(250, 0, 83);
    test_random_traffic(250, 30, 30);

    settle();
    repeat (30) @(posedge clk);
    $display("Covered %0d commands, %0d of them lookups (%0d misses, %0d constant answers),",
             items_sent, queries_sent, misses_expected, const_answers);
    $display("with %0d register writes over four sender and receiver pacing phases.",
             reg_writes);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Run limit reached with %0d results outstanding.", awaited_answers.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/iwwl_pkg.sv
hdl/iwwl_in_if.sv
hdl/iwwl_out_if.sv
hdl/iwwl_cfg_if.sv
hdl/iwwl_ram.sv
hdl/iwwl_walk.sv
hdl/interval_walk_weight_lookup_core.sv
hdl/iwwl_checker.sv
verif/tb_top.sv
